FILE: src/obst_pkg.sv
package obst_pkg;

    localparam int DEF_MAX_KEYS = 16;

    localparam int WEIGHT_W = 16;
    localparam int COST_W   = 32;
    localparam int OUT_IDX_W = 5;

    localparam int IN_TDATA_W  = 2 * WEIGHT_W;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_TUSER_W = 1;

    // Bit positions of the result fields inside the output tdata
    localparam int COST_LSB  = 0;
    localparam int ROOT_LSB  = COST_LSB + COST_W;
    localparam int COUNT_LSB = ROOT_LSB + OUT_IDX_W;
    localparam int PAD_W     = OUT_TDATA_W - COUNT_LSB - OUT_IDX_W;

    // Add and clamp at the top of the cost range
    function automatic logic [COST_W-1:0] sat_add(
        input logic [COST_W-1:0] a,
        input logic [COST_W-1:0] b
    );
        logic [COST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COST_W] ? {COST_W{1'b1}} : s[COST_W-1:0];
    endfunction

endpackage

FILE: src/optimal_bst_cost_root.sv
// Channel  | Dir | Signals                        | Beat contents
// ---------+-----+--------------------------------+----------------------------------------
// s_axis   | in  | tvalid tready tdata[31:0] tlast| one item: key weight, gap weight,
//          |     |                                | tlast marks the final item of a problem
// m_axis   | out | tvalid tready tdata[47:0]      | one result: cost, root key, key count,
//          |     | tuser[0:0]                     | tuser flags dropped items
//
// Loading accepts one item per cycle. The solver then runs the cubic interval program on
// one candidate pipeline: it seeds the tables, scores every cell in order of length, then
// hands the result off. Reset clears the sequencer, the item count and the output valid;
// tables are never cleared. The input is not ready while the solver runs; a stalled result
// holds the solver in its final step and so also delays loading of the next problem.
module optimal_bst_cost_root #(
    parameter int MAX_KEYS = obst_pkg::DEF_MAX_KEYS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [15:0] key_weight, [31:16] gap_weight
    input  logic [obst_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input  logic                               s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [31:0] total_cost, [36:32] root_key, [41:37] key_count, [47:42] zero
    output logic [obst_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // [0] too_many
    output logic [obst_pkg::OUT_TUSER_W-1:0]   m_axis_tuser
);
    import obst_pkg::*;

    // Row index covers 0..MAX_KEYS+1, column index 0..MAX_KEYS
    localparam int ROWS  = MAX_KEYS + 2;
    localparam int COLS  = MAX_KEYS + 1;
    localparam int IDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COL_W = (COLS > 1) ? $clog2(COLS) : 1;

    localparam logic [IDX_W-1:0] ONE     = IDX_W'(1);
    localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_KEYS);
    localparam logic [IDX_W-1:0] FULL    = IDX_W'(MAX_KEYS + 1);

    // Sequencer states
    localparam logic [2:0] S_LOAD    = 3'd0;
    localparam logic [2:0] S_INIT_RD = 3'd1;
    localparam logic [2:0] S_INIT_WR = 3'd2;
    localparam logic [2:0] S_CELL0   = 3'd3;
    localparam logic [2:0] S_CELL1   = 3'd4;
    localparam logic [2:0] S_SCAN    = 3'd5;
    localparam logic [2:0] S_DONE    = 3'd6;

    // Stores
    logic [IN_TDATA_W-1:0] kg_mem   [COLS];
    logic [COST_W-1:0]     w_mem    [ROWS][COLS];
    logic [COST_W-1:0]     cost_mem [ROWS][COLS];

    logic [IN_TDATA_W-1:0] kg_rd;
    logic [COST_W-1:0]     w_rd;
    logic [COST_W-1:0]     cost_rd_a;
    logic [COST_W-1:0]     cost_rd_b;

    // Control
    logic [2:0]       state_reg,    state_next;
    logic [IDX_W-1:0] count_reg,    count_next;
    logic             ovf_reg,      ovf_next;
    logic [IDX_W-1:0] n_reg,        n_next;
    logic             tm_reg,       tm_next;
    logic [IDX_W-1:0] len_reg,      len_next;
    logic [IDX_W-1:0] i_reg,        i_next;
    logic [IDX_W-1:0] r_reg,        r_next;
    logic             issue_reg,    issue_next;
    logic             v1_reg,       v1_next;
    logic             v2_reg,       v2_next;
    logic             first_reg,    first_next;
    logic             out_valid_reg, out_valid_next;

    // Datapath
    logic [IDX_W-1:0]  r1_reg,      r1_next;
    logic [IDX_W-1:0]  r2_reg,      r2_next;
    logic [COST_W-1:0] s1_reg,      s1_next;
    logic [COST_W-1:0] w_reg,       w_next;
    logic [COST_W-1:0] best_reg,    best_next;
    logic [IDX_W-1:0]  broot_reg,   broot_next;
    logic [COST_W-1:0] q0_reg,      q0_next;
    logic [COST_W-1:0] out_cost_reg, out_cost_next;
    logic [IDX_W-1:0]  out_root_reg, out_root_next;
    logic [IDX_W-1:0]  out_n_reg,    out_n_next;
    logic              out_tm_reg,   out_tm_next;

    logic [IDX_W-1:0]  j_idx;
    logic [IDX_W-1:0]  jm1_idx;
    logic [IDX_W-1:0]  rm1_idx;
    logic [IDX_W-1:0]  kg_addr;
    logic              in_beat;
    logic              kg_we;
    logic              w_we;
    logic [IDX_W-1:0]  w_wcol;
    logic [COST_W-1:0] w_wdata;
    logic              cost_we;
    logic [IDX_W-1:0]  cost_wcol;
    logic [COST_W-1:0] cost_wdata;
    logic [COST_W-1:0] gap_ext;
    logic [COST_W-1:0] kq_sum;
    logic [COST_W-1:0] cand;
    logic              scan_end;

    assign j_idx   = i_reg + len_reg - ONE;
    assign jm1_idx = j_idx - ONE;
    assign rm1_idx = r_reg - ONE;
    assign kg_addr = (state_reg == S_INIT_RD) ? (i_reg - ONE) : j_idx;

    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign kg_we    = in_beat && (count_reg < FULL);
    assign gap_ext  = COST_W'(kg_rd[IN_TDATA_W-1:WEIGHT_W]);
    assign kq_sum   = COST_W'({1'b0, kg_rd[WEIGHT_W-1:0]})
                    + COST_W'({1'b0, kg_rd[IN_TDATA_W-1:WEIGHT_W]});
    assign cand     = sat_add(s1_reg, w_reg);
    assign scan_end = !issue_reg && !v1_reg && !v2_reg;

    assign s_axis_tready = (state_reg == S_LOAD);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, OUT_IDX_W'(out_n_reg),
                            OUT_IDX_W'(out_root_reg), out_cost_reg};
    assign m_axis_tuser  = out_tm_reg;

    // Table write ports
    always_comb
    begin
        w_we       = 1'b0;
        w_wcol     = j_idx;
        w_wdata    = sat_add(w_rd, kq_sum);
        cost_we    = 1'b0;
        cost_wcol  = j_idx;
        cost_wdata = best_reg;
        unique case (state_reg)
            S_INIT_WR:
            begin
                w_we       = 1'b1;
                w_wcol     = i_reg - ONE;
                w_wdata    = gap_ext;
                cost_we    = 1'b1;
                cost_wcol  = i_reg - ONE;
                cost_wdata = gap_ext;
            end
            S_CELL1:
            begin
                w_we = 1'b1;
            end
            S_SCAN:
            begin
                cost_we = scan_end;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (kg_we)
        begin
            kg_mem[count_reg[COL_W-1:0]] <= s_axis_tdata;
        end
        kg_rd <= kg_mem[kg_addr[COL_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (w_we)
        begin
            w_mem[i_reg][w_wcol[COL_W-1:0]] <= w_wdata;
        end
        w_rd <= w_mem[i_reg][jm1_idx[COL_W-1:0]];
    end

    // Two read ports: left subtree e[i][r-1], right subtree e[r+1][j]
    always_ff @(posedge clk)
    begin
        if (cost_we)
        begin
            cost_mem[i_reg][cost_wcol[COL_W-1:0]] <= cost_wdata;
        end
        cost_rd_a <= cost_mem[i_reg][rm1_idx[COL_W-1:0]];
        cost_rd_b <= cost_mem[r_reg + ONE][j_idx[COL_W-1:0]];
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        n_next         = n_reg;
        tm_next        = tm_reg;
        len_next       = len_reg;
        i_next         = i_reg;
        r_next         = r_reg;
        issue_next     = issue_reg;
        first_next     = first_reg;
        out_valid_next = out_valid_reg;
        w_next         = w_reg;
        best_next      = best_reg;
        broot_next     = broot_reg;
        q0_next        = q0_reg;
        out_cost_next  = out_cost_reg;
        out_root_next  = out_root_reg;
        out_n_next     = out_n_reg;
        out_tm_next    = out_tm_reg;

        // Candidate pipeline: read tables, add subtrees, add weight and compare
        v1_next = issue_reg;
        r1_next = r_reg;
        v2_next = v1_reg;
        r2_next = r1_reg;
        s1_next = sat_add(cost_rd_a, cost_rd_b);

        if (v2_reg && (first_reg || (cand < best_reg)))
        begin
            best_next  = cand;
            broot_next = r2_reg;
            first_next = 1'b0;
        end

        // Drop the result once the consumer takes it
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_LOAD:
            begin
                if (in_beat)
                begin
                    if (count_reg < FULL)
                    begin
                        count_next = count_reg + ONE;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (s_axis_tlast)
                    begin
                        n_next     = (count_reg < FULL) ? count_reg : MAX_IDX;
                        tm_next    = ovf_reg || (count_reg == FULL);
                        count_next = '0;
                        ovf_next   = 1'b0;
                        i_next     = ONE;
                        state_next = S_INIT_RD;
                    end
                end
            end
            S_INIT_RD:
            begin
                state_next = S_INIT_WR;
            end
            S_INIT_WR:
            begin
                if (i_reg == ONE)
                begin
                    q0_next = gap_ext;
                end
                if (i_reg == n_reg + ONE)
                begin
                    len_next   = ONE;
                    i_next     = ONE;
                    state_next = (n_reg == '0) ? S_DONE : S_CELL0;
                end
                else
                begin
                    i_next     = i_reg + ONE;
                    state_next = S_INIT_RD;
                end
            end
            S_CELL0:
            begin
                state_next = S_CELL1;
            end
            S_CELL1:
            begin
                w_next     = w_wdata;
                r_next     = i_reg;
                issue_next = 1'b1;
                first_next = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (issue_reg)
                begin
                    r_next = r_reg + ONE;
                    if (r_reg == j_idx)
                    begin
                        issue_next = 1'b0;
                    end
                end
                if (scan_end)
                begin
                    // Advance to the next cell, then to the next length
                    if (j_idx < n_reg)
                    begin
                        i_next     = i_reg + ONE;
                        state_next = S_CELL0;
                    end
                    else if (len_reg < n_reg)
                    begin
                        len_next   = len_reg + ONE;
                        i_next     = ONE;
                        state_next = S_CELL0;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_cost_next  = (n_reg == '0) ? q0_reg : best_reg;
                    out_root_next  = (n_reg == '0) ? '0 : broot_reg;
                    out_n_next     = n_reg;
                    out_tm_next    = tm_reg;
                    state_next     = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            issue_reg     <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            issue_reg     <= issue_next;
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        tm_reg       <= tm_next;
        len_reg      <= len_next;
        i_reg        <= i_next;
        r_reg        <= r_next;
        r1_reg       <= r1_next;
        r2_reg       <= r2_next;
        s1_reg       <= s1_next;
        w_reg        <= w_next;
        best_reg     <= best_next;
        broot_reg    <= broot_next;
        q0_reg       <= q0_next;
        out_cost_reg <= out_cost_next;
        out_root_reg <= out_root_next;
        out_n_reg    <= out_n_next;
        out_tm_reg   <= out_tm_next;
    end

endmodule

FILE: src/obst_checker.sv
module obst_checker #(
    parameter int MAX_KEYS = obst_pkg::DEF_MAX_KEYS
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [obst_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input logic                             s_axis_tlast,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [obst_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [obst_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);
    import obst_pkg::*;

    logic [OUT_IDX_W-1:0] root_f;
    logic [OUT_IDX_W-1:0] count_f;
    logic                 fields_exact;

    assign root_f       = m_axis_tdata[ROOT_LSB +: OUT_IDX_W];
    assign count_f      = m_axis_tdata[COUNT_LSB +: OUT_IDX_W];
    assign fields_exact = (MAX_KEYS < (1 << OUT_IDX_W));

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid
            && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed or vanished");

    // The final item starts the solver, so the input stalls next cycle
    a_solve_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input ready right after final item");

    // Key count stays within the table size
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !fields_exact || (count_f <= OUT_IDX_W'(MAX_KEYS)))
        else $error("key count beyond table size");

    // Root is zero exactly when there are no keys, and never past the last key
    a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !fields_exact
            || (((root_f == '0) == (count_f == '0)) && (root_f <= count_f)))
        else $error("root key outside key range");

endmodule

bind optimal_bst_cost_root obst_checker #(.MAX_KEYS(MAX_KEYS)) u_obst_checker (.*);
